// ===== src/swt_pkg.sv =====
`timescale 1ns / 1ps

package swt_pkg;

  localparam int MaxRes = 3;
  localparam int ColW = 13;

  typedef enum logic [3:0] {
    ModeIdle       = 4'd0,
    ModeWord       = 4'd1,
    ModeSq         = 4'd2,
    ModeDq         = 4'd3,
    ModeEsc        = 4'd4,
    ModeEscDq      = 4'd5,
    ModePipe       = 4'd6,
    ModeGt         = 4'd7,
    ModeAmp        = 4'd8,
    ModeAmpWait    = 4'd9,
    ModeComment    = 4'd10,
    ModeAmpComment = 4'd11
  } mode_e;

  typedef enum logic [3:0] {
    KindChar   = 4'd0,
    KindWend   = 4'd1,
    KindPipe   = 4'd2,
    KindOr     = 4'd3,
    KindAmp    = 4'd4,
    KindAnd    = 4'd5,
    KindSemi   = 4'd6,
    KindIn     = 4'd7,
    KindOut    = 4'd8,
    KindAppend = 4'd9,
    KindEnd    = 4'd10,
    KindErr    = 4'd11
  } kind_e;

  localparam logic [1:0] QuoteNone   = 2'd0;
  localparam logic [1:0] QuoteSingle = 2'd1;
  localparam logic [1:0] QuoteDouble = 2'd2;
  localparam logic [1:0] QuoteEscape = 2'd3;

  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrParen     = 3'd1;
  localparam logic [2:0] ErrLoneAmp   = 3'd2;
  localparam logic [2:0] ErrOpenSq    = 3'd3;
  localparam logic [2:0] ErrOpenDq    = 3'd4;
  localparam logic [2:0] ErrBackslash = 3'd5;
  localparam logic [2:0] ErrEmptyWord = 3'd6;

  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChBtick  = 8'h60;
  localparam logic [7:0] ChPipe   = 8'h7C;

  typedef struct packed {
    logic [7:0] character;
    logic       end_marker;
  } swt_in_t;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      character_res;
    logic [1:0]      quote_kind;
    logic [ColW-1:0] column;
    logic [2:0]      error_code;
    logic            last;
  } swt_out_t;

  // All results caused by one input item, filled from index zero.
  typedef struct packed {
    logic [1:0]                count;
    swt_out_t [MaxRes-1:0]     items;
  } swt_bundle_t;

  function automatic logic is_blank(logic [7:0] c);
    return c inside {ChSpace, ChTab};
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c inside {ChPipe, ChAmp, ChSemi, ChLt, ChGt, ChLParen, ChRParen};
  endfunction

endpackage

// ===== src/swt_lexer.sv =====
`timescale 1ns / 1ps

module swt_lexer #(
  parameter int MaxLine = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  swt_pkg::swt_in_t    item_i,
  output swt_pkg::swt_bundle_t bundle_o
);
  import swt_pkg::*;

  localparam int PosW = $clog2(MaxLine + 1);
  localparam int SumW = (PosW + 1 > ColW) ? PosW + 1 : ColW;
  localparam int ColCap = (MaxLine < 8191) ? MaxLine : 8191;

  mode_e           mode_q, mode_d;
  logic            has_text_q, has_text_d;
  logic [ColW-1:0] word_col_q, word_col_d;
  logic [ColW-1:0] quote_col_q, quote_col_d;
  logic [ColW-1:0] esc_col_q, esc_col_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            err_q, err_d;

  logic [SumW-1:0] pos_sum;
  logic [ColW-1:0] col;
  logic [7:0]      c;
  logic [1:0]      n;
  logic            redo;
  logic            do_wc;
  logic            flush_err;

  function automatic swt_out_t mk(kind_e k, logic [7:0] ch, logic [1:0] q,
                                  logic [ColW-1:0] cl, logic [2:0] e);
    swt_out_t r;
    r.kind          = k;
    r.character_res = ch;
    r.quote_kind    = q;
    r.column        = cl;
    r.error_code    = e;
    r.last          = 1'b0;
    return r;
  endfunction

  assign c       = item_i.character;
  assign pos_sum = SumW'(pos_q) + SumW'(1);
  assign col     = (pos_sum > SumW'(ColCap)) ? ColW'(ColCap) : pos_sum[ColW-1:0];

  always_comb begin
    mode_d      = mode_q;
    has_text_d  = has_text_q;
    word_col_d  = word_col_q;
    quote_col_d = quote_col_q;
    esc_col_d   = esc_col_q;
    pos_d       = pos_q;
    err_d       = err_q;
    bundle_o    = '0;
    n           = 2'd0;
    redo        = 1'b0;
    do_wc       = 1'b0;
    flush_err   = 1'b0;

    if (item_i.end_marker) begin
      if (!err_q) begin
        case (mode_q)
          ModeWord: begin
            if (!has_text_q) begin
              bundle_o.items[n] = mk(KindErr, 8'd0, QuoteNone, word_col_q, ErrEmptyWord);
              flush_err = 1'b1;
            end else begin
              bundle_o.items[n] = mk(KindWend, 8'd0, QuoteNone, word_col_q, ErrNone);
            end
            n = n + 2'd1;
          end
          ModeSq: begin
            bundle_o.items[n] = mk(KindErr, 8'd0, QuoteNone, quote_col_q, ErrOpenSq);
            flush_err = 1'b1;
            n = n + 2'd1;
          end
          ModeDq: begin
            bundle_o.items[n] = mk(KindErr, 8'd0, QuoteNone, quote_col_q, ErrOpenDq);
            flush_err = 1'b1;
            n = n + 2'd1;
          end
          ModeEsc, ModeEscDq: begin
            bundle_o.items[n] = mk(KindErr, 8'd0, QuoteNone, esc_col_q, ErrBackslash);
            flush_err = 1'b1;
            n = n + 2'd1;
          end
          ModePipe: begin
            bundle_o.items[n] = mk(KindPipe, 8'd0, QuoteNone, '0, ErrNone);
            n = n + 2'd1;
          end
          ModeGt: begin
            bundle_o.items[n] = mk(KindOut, 8'd0, QuoteNone, '0, ErrNone);
            n = n + 2'd1;
          end
          ModeAmp, ModeAmpWait, ModeAmpComment: begin
            bundle_o.items[n] = mk(KindAmp, 8'd0, QuoteNone, '0, ErrNone);
            n = n + 2'd1;
          end
          default: begin
          end
        endcase
        if (!flush_err) begin
          bundle_o.items[n] = mk(KindEnd, 8'd0, QuoteNone, '0, ErrNone);
          n = n + 2'd1;
        end
      end
      // Every end of line starts the next line from a clean state.
      mode_d      = ModeIdle;
      has_text_d  = 1'b0;
      word_col_d  = '0;
      quote_col_d = '0;
      esc_col_d   = '0;
      pos_d       = '0;
      err_d       = 1'b0;
    end else if (!err_q) begin
      case (mode_q)
        ModeIdle: redo = 1'b1;
        ModeWord: begin
          if (is_blank(c) || is_op(c)) begin
            if (!has_text_q) begin
              bundle_o.items[n] = mk(KindErr, 8'd0, QuoteNone, word_col_q, ErrEmptyWord);
              err_d = 1'b1;
            end else begin
              bundle_o.items[n] = mk(KindWend, 8'd0, QuoteNone, word_col_q, ErrNone);
              redo = is_op(c);
            end
            n = n + 2'd1;
            mode_d = ModeIdle;
          end else begin
            do_wc = 1'b1;
          end
        end
        ModeSq: begin
          if (c == ChSquote) begin
            mode_d = ModeWord;
          end else begin
            has_text_d = 1'b1;
            bundle_o.items[n] = mk(KindChar, c, QuoteSingle, '0, ErrNone);
            n = n + 2'd1;
          end
        end
        ModeDq: begin
          if (c == ChDquote) begin
            mode_d = ModeWord;
          end else if (c == ChBslash) begin
            esc_col_d = col;
            mode_d    = ModeEscDq;
          end else begin
            has_text_d = 1'b1;
            bundle_o.items[n] = mk(KindChar, c, QuoteDouble, '0, ErrNone);
            n = n + 2'd1;
          end
        end
        ModeEsc: begin
          has_text_d = 1'b1;
          bundle_o.items[n] = mk(KindChar, c, QuoteEscape, '0, ErrNone);
          n = n + 2'd1;
          mode_d = ModeWord;
        end
        ModeEscDq: begin
          has_text_d = 1'b1;
          if (c inside {ChDquote, ChBslash, ChDollar, ChBtick}) begin
            bundle_o.items[n] = mk(KindChar, c, QuoteEscape, '0, ErrNone);
            n = n + 2'd1;
          end else begin
            // The backslash has no special meaning here and is kept as text.
            bundle_o.items[n] = mk(KindChar, ChBslash, QuoteEscape, '0, ErrNone);
            n = n + 2'd1;
            bundle_o.items[n] = mk(KindChar, c, QuoteNone, '0, ErrNone);
            n = n + 2'd1;
          end
          mode_d = ModeDq;
        end
        ModePipe: begin
          mode_d = ModeIdle;
          if (c == ChPipe) begin
            bundle_o.items[n] = mk(KindOr, 8'd0, QuoteNone, '0, ErrNone);
          end else begin
            bundle_o.items[n] = mk(KindPipe, 8'd0, QuoteNone, '0, ErrNone);
            redo = 1'b1;
          end
          n = n + 2'd1;
        end
        ModeGt: begin
          mode_d = ModeIdle;
          if (c == ChGt) begin
            bundle_o.items[n] = mk(KindAppend, 8'd0, QuoteNone, '0, ErrNone);
          end else begin
            bundle_o.items[n] = mk(KindOut, 8'd0, QuoteNone, '0, ErrNone);
            redo = 1'b1;
          end
          n = n + 2'd1;
        end
        ModeAmp: begin
          if (c == ChAmp) begin
            mode_d = ModeIdle;
            bundle_o.items[n] = mk(KindAnd, 8'd0, QuoteNone, '0, ErrNone);
            n = n + 2'd1;
          end else if (is_blank(c)) begin
            mode_d = ModeAmpWait;
          end else if (c == ChHash) begin
            mode_d = ModeAmpComment;
          end else begin
            bundle_o.items[n] = mk(KindErr, 8'd0, QuoteNone, word_col_q, ErrLoneAmp);
            n = n + 2'd1;
            err_d  = 1'b1;
            mode_d = ModeIdle;
          end
        end
        ModeAmpWait: begin
          if (c == ChHash) begin
            mode_d = ModeAmpComment;
          end else if (!is_blank(c)) begin
            bundle_o.items[n] = mk(KindErr, 8'd0, QuoteNone, word_col_q, ErrLoneAmp);
            n = n + 2'd1;
            err_d  = 1'b1;
            mode_d = ModeIdle;
          end
        end
        default: begin
        end
      endcase

      // The byte is looked at again as the possible start of a new token.
      if (redo) begin
        case (c)
          ChSpace, ChTab: begin
          end
          ChHash: mode_d = ModeComment;
          ChPipe: mode_d = ModePipe;
          ChGt:   mode_d = ModeGt;
          ChAmp: begin
            mode_d     = ModeAmp;
            word_col_d = col;
          end
          ChSemi: begin
            bundle_o.items[n] = mk(KindSemi, 8'd0, QuoteNone, '0, ErrNone);
            n = n + 2'd1;
          end
          ChLt: begin
            bundle_o.items[n] = mk(KindIn, 8'd0, QuoteNone, '0, ErrNone);
            n = n + 2'd1;
          end
          ChLParen, ChRParen: begin
            bundle_o.items[n] = mk(KindErr, 8'd0, QuoteNone, col, ErrParen);
            n = n + 2'd1;
            err_d  = 1'b1;
            mode_d = ModeIdle;
          end
          default: begin
            has_text_d = 1'b0;
            word_col_d = col;
            mode_d     = ModeWord;
            do_wc      = 1'b1;
          end
        endcase
      end

      // A byte inside a word outside of quotes.
      if (do_wc) begin
        if (c == ChSquote) begin
          quote_col_d = col;
          mode_d      = ModeSq;
        end else if (c == ChDquote) begin
          quote_col_d = col;
          mode_d      = ModeDq;
        end else if (c == ChBslash) begin
          esc_col_d = col;
          mode_d    = ModeEsc;
        end else begin
          has_text_d = 1'b1;
          bundle_o.items[n] = mk(KindChar, c, QuoteNone, '0, ErrNone);
          n = n + 2'd1;
        end
      end

      if (pos_q < PosW'(MaxLine)) begin
        pos_d = pos_q + PosW'(1);
      end
    end
    bundle_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      has_text_q  <= 1'b0;
      word_col_q  <= '0;
      quote_col_q <= '0;
      esc_col_q   <= '0;
      pos_q       <= '0;
      err_q       <= 1'b0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      has_text_q  <= has_text_d;
      word_col_q  <= word_col_d;
      quote_col_q <= quote_col_d;
      esc_col_q   <= esc_col_d;
      pos_q       <= pos_d;
      err_q       <= err_d;
    end
  end

endmodule

// ===== src/swt_result_buf.sv =====
`timescale 1ns / 1ps

module swt_result_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  swt_pkg::swt_bundle_t bundle_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output swt_pkg::swt_out_t    out_data_o
);
  import swt_pkg::*;

  swt_out_t [MaxRes-1:0] slots_q;
  logic [1:0]            cnt_q, cnt_d;
  logic [1:0]            idx_q, idx_d;
  logic                  take;
  logic                  finishing;

  assign out_valid_o = (cnt_q != 2'd0);
  assign take        = out_valid_o && out_ready_i;
  assign finishing   = take && (idx_q == cnt_q - 2'd1);
  assign can_load_o  = (cnt_q == 2'd0) || finishing;

  always_comb begin
    out_data_o      = slots_q[idx_q];
    out_data_o.last = (idx_q == cnt_q - 2'd1);
  end

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = bundle_i.count;
      idx_d = 2'd0;
    end else if (finishing) begin
      cnt_d = 2'd0;
      idx_d = 2'd0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slots_q <= bundle_i.items;
    end
  end

endmodule

// ===== src/shell_word_tokenizer.sv =====
`timescale 1ns / 1ps

// Command-line tokenizer: one byte (or an end-of-line marker) per input
// transaction, word characters, word ends, operators, end of line and errors
// out, one result per output transaction with last marking the final result
// of each input. The input byte is registered, classified combinationally
// against the lexer state and its results land in a three-entry result
// register; a new byte is taken every cycle as long as each byte causes at
// most one result and the output is ready; a byte with several results
// holds the single output port until all are taken. Bytes without results
// (blanks, quotes, comment text) pass at one per cycle while no results wait.
// After an error the rest of the line, end marker included, gives no results.
module shell_word_tokenizer #(
  parameter int MaxLine = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  swt_pkg::swt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output swt_pkg::swt_out_t out_data_o
);
  import swt_pkg::*;

  swt_in_t     in_data_q;
  logic        in_vld_q, in_vld_d;
  logic        can_load;
  logic        adv;
  logic        accept;
  swt_bundle_t bundle;

  assign adv        = in_vld_q && can_load;
  assign in_ready_o = !in_vld_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= in_data_i;
    end
  end

  swt_lexer #(
    .MaxLine(MaxLine)
  ) u_lexer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .item_i  (in_data_q),
    .bundle_o(bundle)
  );

  swt_result_buf u_result_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (adv),
    .bundle_i   (bundle),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
